@@ hw/rtl/hlt_pkg.sv @@
// Heartbeat lease table package: payload structs, status codes, default sizes
// and the controller/datapath command and status structs.
// No dependencies.
package hlt_pkg;

  localparam int HLT_TABLE_ENTRIES    = 16;
  localparam int HLT_KEY_BUFFER_BYTES = 8;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_CAPACITY = 2'd2;

  localparam logic ACT_HEARTBEAT = 1'b0;
  localparam logic ACT_QUERY     = 1'b1;

  typedef struct packed {
    logic        action;
    logic [63:0] client_key;
    logic [7:0]  key_length;
    logic [63:0] now_time;
    logic [63:0] lease_length;
  } hlt_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       active;
  } hlt_out_t;

  typedef struct packed {
    logic accept;
    logic scan_rd;
    logic calc_diff;
    logic finish;
  } hlt_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic skip_scan;
    logic is_query;
  } hlt_sts_t;

endpackage

@@ hw/rtl/hlt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/hlt_datapath.sv @@
// Heartbeat lease table datapath: item registers, record memory, used flags,
// scan compare, liveness arithmetic and result register. Uses hlt_pkg, hlt_ram.
module hlt_datapath #(
  parameter int TABLE_ENTRIES    = hlt_pkg::HLT_TABLE_ENTRIES,
  parameter int KEY_BUFFER_BYTES = hlt_pkg::HLT_KEY_BUFFER_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  hlt_pkg::hlt_in_t  in_data,
  input  hlt_pkg::hlt_cmd_t cmd,
  output hlt_pkg::hlt_sts_t sts,
  output hlt_pkg::hlt_out_t out_data
);
  import hlt_pkg::*;

  localparam int KW = 8 * (KEY_BUFFER_BYTES - 1);
  localparam int LW = $clog2(KEY_BUFFER_BYTES);
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int RW = KW + LW + 128;
  localparam logic [7:0]    MAX_LEN  = 8'(KEY_BUFFER_BYTES - 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  logic          action_r;
  logic [KW-1:0] key_r;
  logic [LW-1:0] len_r;
  logic [63:0]   now_r;
  logic [63:0]   lease_r;
  logic          empty_r;
  logic          too_long_r;
  logic          lease_zero_r;

  logic [KW-1:0] key_m;

  logic [IW-1:0] cnt_r;
  logic          pend_valid_r;
  logic [IW-1:0] pend_idx_r;
  logic [TABLE_ENTRIES-1:0] used_r;

  logic          hit_r;
  logic [IW-1:0] hit_idx_r;
  logic [63:0]   hit_seen_r;
  logic [63:0]   hit_lease_r;
  logic          free_r;
  logic [IW-1:0] free_idx_r;
  logic [63:0]   diff_r;
  logic          borrow_r;

  logic [RW-1:0] rdata;
  logic [RW-1:0] wdata;
  logic [IW-1:0] waddr;
  logic          we;
  logic [KW-1:0] rd_key;
  logic [LW-1:0] rd_len;
  logic [63:0]   rd_seen;
  logic [63:0]   rd_lease;
  logic          match;
  logic [64:0]   diff_w;
  logic [1:0]    status;
  logic          active;
  hlt_out_t      out_r;

  always_comb begin
    for (int b = 0; b < KEY_BUFFER_BYTES - 1; b++) begin
      key_m[8*b +: 8] = (8'(b) < in_data.key_length) ? in_data.client_key[8*b +: 8] : 8'h00;
    end
  end

  assign rd_key   = rdata[RW-1 -: KW];
  assign rd_len   = rdata[128 +: LW];
  assign rd_seen  = rdata[64 +: 64];
  assign rd_lease = rdata[0 +: 64];

  assign match = pend_valid_r && used_r[pend_idx_r] && (rd_len == len_r) && (rd_key == key_r);

  assign diff_w = {1'b0, now_r} - {1'b0, hit_seen_r};

  always_comb begin
    status = ST_OK;
    active = 1'b0;
    if (action_r == ACT_QUERY) begin
      active = hit_r && (borrow_r || (diff_r <= hit_lease_r));
    end else if (empty_r || lease_zero_r) begin
      status = ST_INVALID;
    end else if (too_long_r || !(hit_r || free_r)) begin
      status = ST_CAPACITY;
    end
  end

  assign we    = cmd.finish && (action_r == ACT_HEARTBEAT) && (status == ST_OK);
  assign waddr = hit_r ? hit_idx_r : free_idx_r;
  assign wdata = {key_r, len_r, now_r, lease_r};

  hlt_ram #(
    .WIDTH(RW),
    .DEPTH(TABLE_ENTRIES)
  ) u_rec_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (cmd.scan_rd),
    .raddr(cnt_r),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      action_r     <= in_data.action;
      key_r        <= key_m;
      len_r        <= in_data.key_length[LW-1:0];
      now_r        <= in_data.now_time;
      lease_r      <= in_data.lease_length;
      empty_r      <= (in_data.key_length == 8'd0);
      too_long_r   <= (in_data.key_length > MAX_LEN);
      lease_zero_r <= (in_data.lease_length == 64'd0);
    end
    if (match && !hit_r) begin
      hit_idx_r   <= pend_idx_r;
      hit_seen_r  <= rd_seen;
      hit_lease_r <= rd_lease;
    end
    if (pend_valid_r && !used_r[pend_idx_r] && !free_r) begin
      free_idx_r <= pend_idx_r;
    end
    if (cmd.calc_diff) begin
      diff_r   <= diff_w[63:0];
      borrow_r <= diff_w[64];
    end
    if (cmd.finish) begin
      out_r.status <= status;
      out_r.active <= active;
    end
    pend_idx_r <= cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r       <= '0;
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
      hit_r        <= 1'b0;
      free_r       <= 1'b0;
    end else begin
      pend_valid_r <= cmd.scan_rd;
      if (cmd.accept) begin
        cnt_r  <= '0;
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end else begin
        if (cmd.scan_rd) begin
          cnt_r <= cnt_r + 1'b1;
        end
        if (match) begin
          hit_r <= 1'b1;
        end
        if (pend_valid_r && !used_r[pend_idx_r]) begin
          free_r <= 1'b1;
        end
      end
      if (we) begin
        used_r[waddr] <= 1'b1;
      end
    end
  end

  assign sts.scan_last = (cnt_r == LAST_IDX);
  assign sts.skip_scan = empty_r || too_long_r || ((action_r == ACT_HEARTBEAT) && lease_zero_r);
  assign sts.is_query  = (action_r == ACT_QUERY);
  assign out_data      = out_r;

endmodule

@@ hw/rtl/hlt_ctrl.sv @@
// Heartbeat lease table controller: sequences accept, table scan, liveness
// arithmetic and result transfer. Uses hlt_pkg.
module hlt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  hlt_pkg::hlt_sts_t sts,
  output hlt_pkg::hlt_cmd_t cmd
);
  import hlt_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_DIFF   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.skip_scan) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.scan_rd = 1'b1;
          if (sts.scan_last) begin
            state_nxt = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        state_nxt = sts.is_query ? S_DIFF : S_FINISH;
      end
      S_DIFF: begin
        cmd.calc_diff = 1'b1;
        state_nxt     = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ hw/rtl/heartbeat_lease_table_core.sv @@
// Heartbeat lease table top level: controller plus datapath.
// Uses hlt_pkg, hlt_ctrl, hlt_datapath.
//
// Keeps TABLE_ENTRIES client lease records in a record memory with one write
// port and one read port and handles one heartbeat or query at a time. A
// heartbeat or query with a storable key walks the whole table, one record
// per cycle through the memory's read port, then passes a drain step, a
// difference step for a query only, and the finish step that writes the
// result register; an item with an empty or overlong key, or a heartbeat
// with a zero lease, skips the scan and goes straight to finish. Used flags
// are flip-flops cleared by reset, so no clearing pass is needed. A finished
// result sits in an output register; the next item is accepted while it waits.
module heartbeat_lease_table_core #(
  parameter int TABLE_ENTRIES    = hlt_pkg::HLT_TABLE_ENTRIES,
  parameter int KEY_BUFFER_BYTES = hlt_pkg::HLT_KEY_BUFFER_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hlt_pkg::hlt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output hlt_pkg::hlt_out_t out_data
);
  import hlt_pkg::*;

  hlt_cmd_t cmd;
  hlt_sts_t sts;

  hlt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  hlt_datapath #(
    .TABLE_ENTRIES   (TABLE_ENTRIES),
    .KEY_BUFFER_BYTES(KEY_BUFFER_BYTES)
  ) u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .sts     (sts),
    .out_data(out_data)
  );

endmodule

@@ test/lease_table_checker.sv @@
`timescale 1ns / 100ps
// Lease table checker: watches both channels of heartbeat_lease_table_core,
// predicts each result from its own copy of the client table and compares.
// Depends on hlt_pkg.
module lease_table_checker #(
  parameter int TABLE_ENTRIES    = hlt_pkg::HLT_TABLE_ENTRIES,
  parameter int KEY_BUFFER_BYTES = hlt_pkg::HLT_KEY_BUFFER_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  hlt_pkg::hlt_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  hlt_pkg::hlt_out_t out_data,
  output int                fail_count,
  output int                pending,
  output int                results_checked,
  output int                active_seen,
  output int                invalid_seen,
  output int                capacity_seen
);
  import hlt_pkg::*;

  logic        lease_used    [TABLE_ENTRIES];
  logic [63:0] lease_key     [TABLE_ENTRIES];
  logic [7:0]  lease_key_len [TABLE_ENTRIES];
  logic [63:0] lease_seen    [TABLE_ENTRIES];
  logic [63:0] lease_span    [TABLE_ENTRIES];
  hlt_out_t    expected_replies [$];

  function automatic logic [63:0] low_bytes(logic [63:0] key, logic [7:0] len);
    if (len == 0) return 64'd0;
    return key & ((64'd1 << (8 * len)) - 64'd1);
  endfunction

  function automatic int find_lease(logic [63:0] key, logic [7:0] len);
    int hit;
    hit = -1;
    if (len == 0 || len > KEY_BUFFER_BYTES - 1) return -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (hit < 0 && lease_used[i] && lease_key_len[i] == len &&
          lease_key[i] == low_bytes(key, len)) hit = i;
    end
    return hit;
  endfunction

  // Works out one reply and applies the heartbeat to the table copy.
  function automatic hlt_out_t predict_reply(hlt_in_t item);
    hlt_out_t reply;
    int       hit;
    int       free_idx;
    reply    = '0;
    hit      = find_lease(item.client_key, item.key_length);
    free_idx = -1;
    if (item.action == ACT_QUERY) begin
      if (hit >= 0 && (item.now_time < lease_seen[hit] ||
                       item.now_time - lease_seen[hit] <= lease_span[hit]))
        reply.active = 1'b1;
    end else if (item.key_length == 0 || item.lease_length == 0) begin
      reply.status = ST_INVALID;
    end else if (hit >= 0) begin
      lease_seen[hit] = item.now_time;
      lease_span[hit] = item.lease_length;
    end else begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (free_idx < 0 && !lease_used[i]) free_idx = i;
      end
      if (free_idx < 0 || item.key_length > KEY_BUFFER_BYTES - 1) begin
        reply.status = ST_CAPACITY;
      end else begin
        lease_used[free_idx]    = 1'b1;
        lease_key[free_idx]     = low_bytes(item.client_key, item.key_length);
        lease_key_len[free_idx] = item.key_length;
        lease_seen[free_idx]    = item.now_time;
        lease_span[free_idx]    = item.lease_length;
      end
    end
    return reply;
  endfunction

  task automatic report_mismatch(string what);
    $display("checker: mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    hlt_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        lease_used[i]    = 1'b0;
        lease_key[i]     = '0;
        lease_key_len[i] = '0;
        lease_seen[i]    = '0;
        lease_span[i]    = '0;
      end
      expected_replies.delete();
      fail_count      = 0;
      results_checked = 0;
      active_seen     = 0;
      invalid_seen    = 0;
      capacity_seen   = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = expected_replies.pop_front();
          results_checked++;
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_data.status, want.status));
          if (out_data.active !== want.active)
            report_mismatch($sformatf("active %0b, expected %0b",
                                      out_data.active, want.active));
          if (want.active) active_seen++;
          if (want.status == ST_INVALID) invalid_seen++;
          if (want.status == ST_CAPACITY) capacity_seen++;
        end
      end
      if (in_valid && !in_stall) expected_replies.push_back(predict_reply(in_data));
    end
    pending = expected_replies.size();
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// Testbench top for heartbeat_lease_table_core: clock, reset, stimulus, verdict.
// Depends on hlt_pkg, heartbeat_lease_table_core and lease_table_checker.
module testbench;
  import hlt_pkg::*;

  localparam int TABLE_ENTRIES    = HLT_TABLE_ENTRIES;
  localparam int KEY_BUFFER_BYTES = HLT_KEY_BUFFER_BYTES;
  localparam int MAX_KEY_CHARS    = KEY_BUFFER_BYTES - 1;
  localparam int KEY_POOL         = 24;
  localparam int RANDOM_ITEMS     = 1230;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int DRAIN_CYCLES     = TABLE_ENTRIES + 8;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  hlt_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  hlt_out_t out_data;

  int fail_count;
  int pending;
  int results_checked;
  int active_seen;
  int invalid_seen;
  int capacity_seen;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count   = 0;
  int items_sent    = 0;

  logic [63:0] pool_key [KEY_POOL];
  logic [7:0]  pool_len [KEY_POOL];
  logic [63:0] clock_ms;

  heartbeat_lease_table_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  lease_table_checker #(
    .TABLE_ENTRIES    (TABLE_ENTRIES),
    .KEY_BUFFER_BYTES (KEY_BUFFER_BYTES)
  ) lease_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .active_seen     (active_seen),
    .invalid_seen    (invalid_seen),
    .capacity_seen   (capacity_seen)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: timed out after %0d cycles", cycle_count);
      $display("testbench: FAIL");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] char_mask(logic [7:0] len);
    if (len >= 8) return '1;
    return (64'd1 << (8 * len)) - 64'd1;
  endfunction

  // Random junk above the key length; the block must ignore it.
  function automatic logic [63:0] with_junk(logic [63:0] key, logic [7:0] len);
    return (key & char_mask(len)) | (rand64() & ~char_mask(len));
  endfunction

  function automatic hlt_in_t make_item(logic act, logic [63:0] key, logic [7:0] len,
                                        logic [63:0] now, logic [63:0] lease);
    hlt_in_t item;
    item.action       = act;
    item.client_key   = key;
    item.key_length   = len;
    item.now_time     = now;
    item.lease_length = lease;
    return item;
  endfunction

  // Called just after a falling edge; returns just after a falling edge.
  task automatic send_item(input hlt_in_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_for_replies();
    in_valid = 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  task automatic send_random();
    hlt_in_t item;
    int      pick;
    clock_ms += 64'($urandom_range(0, 300));
    if ($urandom_range(0, 99) < 75) begin
      pick              = $urandom_range(0, KEY_POOL - 1);
      item.action       = 1'($urandom_range(0, 1));
      item.key_length   = pool_len[pick];
      item.client_key   = with_junk(pool_key[pick], pool_len[pick]);
      item.now_time     = clock_ms;
      item.lease_length = 64'($urandom_range(1, 600));
      if ($urandom_range(0, 19) == 0) item.now_time = clock_ms - 64'($urandom_range(0, 500));
      if ($urandom_range(0, 19) == 0) begin
        item.now_time     = rand64();
        item.lease_length = rand64();
      end
    end else begin
      item.action       = 1'($urandom_range(0, 1));
      item.client_key   = rand64();
      item.key_length   = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(0, 9));
      item.now_time     = ($urandom_range(0, 1) == 0) ? rand64() : clock_ms;
      item.lease_length = ($urandom_range(0, 3) == 0) ? 64'd0 : rand64();
    end
    send_item(item);
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    clock_ms = 64'd1000;
    for (int i = 0; i < KEY_POOL; i++) begin
      pool_len[i] = 8'($urandom_range(1, MAX_KEY_CHARS));
      pool_key[i] = rand64() & char_mask(pool_len[i]);
    end
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 32;
    recv_idle_pct = 74;

    // empty table, bad arguments, overlong keys
    send_item(make_item(ACT_QUERY, 64'h41, 8'd1, 64'd0, 64'd0));
    send_item(make_item(ACT_HEARTBEAT, 64'h0, 8'd0, 64'd5, 64'd10));
    send_item(make_item(ACT_HEARTBEAT, 64'h41, 8'd1, 64'd5, 64'd0));
    send_item(make_item(ACT_HEARTBEAT, '1, 8'd8, 64'd5, 64'd10));
    send_item(make_item(ACT_HEARTBEAT, '1, 8'd255, '1, '1));
    // longest storable key, full-range times
    send_item(make_item(ACT_HEARTBEAT, '1, 8'(MAX_KEY_CHARS), 64'd0, '1));
    send_item(make_item(ACT_QUERY, '1, 8'(MAX_KEY_CHARS), '1, 64'd0));
    send_item(make_item(ACT_QUERY, '1, 8'd8, '1, 64'd0));
    // lease edges, time running backwards, length mismatch
    send_item(make_item(ACT_HEARTBEAT, 64'hABCD_EF12, 8'd1, 64'd100, 64'd1));
    send_item(make_item(ACT_QUERY, 64'h12, 8'd1, 64'd101, 64'd0));
    send_item(make_item(ACT_QUERY, 64'h12, 8'd1, 64'd102, 64'd0));
    send_item(make_item(ACT_QUERY, 64'h12, 8'd1, 64'd50, 64'd0));
    send_item(make_item(ACT_QUERY, 64'h12, 8'd2, 64'd100, 64'd0));
    // NUL character inside the key
    send_item(make_item(ACT_HEARTBEAT, 64'hFF00_0012, 8'd2, 64'd100, 64'd5));
    send_item(make_item(ACT_QUERY, 64'h0012, 8'd2, 64'd105, 64'd0));
    send_item(make_item(ACT_QUERY, 64'h0, 8'd0, 64'd100, 64'd0));
    // refresh to the top of time
    send_item(make_item(ACT_HEARTBEAT, 64'h12, 8'd1, '1, '1));
    send_item(make_item(ACT_QUERY, 64'h12, 8'd1, 64'd0, 64'd0));
    send_item(make_item(ACT_HEARTBEAT, 64'h0, 8'd1, 64'd7, 64'd0));
    send_item(make_item(ACT_HEARTBEAT, 64'h0, 8'd1, 64'd7, 64'd3));
    send_item(make_item(ACT_QUERY, 64'h0, 8'd1, 64'd10, 64'd0));
    send_item(make_item(ACT_QUERY, 64'h0, 8'd1, 64'd11, 64'd0));
    wait_for_replies();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 74 : 0;
      recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 32 : 0;
      repeat (RANDOM_ITEMS / 3) begin
        send_random();
        if ($urandom_range(0, 49) == 0) wait_for_replies();
      end
      wait_for_replies();
    end

    in_valid = 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("testbench: %0d input transfers, %0d results checked",
             items_sent, results_checked);
    $display("testbench: %0d active answers, %0d invalid, %0d capacity rejects",
             active_seen, invalid_seen, capacity_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/hlt_pkg.sv
hw/rtl/hlt_ram.sv
hw/rtl/hlt_datapath.sv
hw/rtl/hlt_ctrl.sv
hw/rtl/heartbeat_lease_table_core.sv
test/lease_table_checker.sv
test/testbench.sv
